@@ rtl/core/mqtt_publish_packet_parser_top_defines.svh @@
// ----------------------------------------------------------------------------
// mqtt publish parser assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef MQTT_PUBLISH_PACKET_PARSER_TOP_DEFINES_SVH
`define MQTT_PUBLISH_PACKET_PARSER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MPP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpp check failed");

// next-cycle implication, sampled on clk, off during reset
`define MPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpp check failed");

`endif

@@ rtl/core/mpp_pkg.sv @@
// ----------------------------------------------------------------------------
// mpp_pkg
// types and codes shared by the mqtt publish parser
// ----------------------------------------------------------------------------
`default_nettype none

package mpp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_TLEN_HI = 3'd2,
        PH_TLEN_LO = 3'd3,
        PH_TOPIC   = 3'd4,
        PH_ID      = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_DROP    = 3'd7
    } phase_t;

    localparam logic [2:0] CLS_HEADER  = 3'd0;
    localparam logic [2:0] CLS_LENGTH  = 3'd1;
    localparam logic [2:0] CLS_TLEN    = 3'd2;
    localparam logic [2:0] CLS_TOPIC   = 3'd3;
    localparam logic [2:0] CLS_ID      = 3'd4;
    localparam logic [2:0] CLS_PAYLOAD = 3'd5;
    localparam logic [2:0] CLS_DROP    = 3'd6;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_TOO_LONG   = 2'd2;
    localparam logic [1:0] ST_BAD_LENGTH = 2'd3;

    localparam logic [7:0] HDR_QOS0 = 8'h30;
    localparam logic [7:0] HDR_QOS1 = 8'h32;
    localparam logic [7:0] HDR_QOS2 = 8'h34;

    localparam int LEN_W   = 28;
    localparam int TOPIC_W = 16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_packet;
    } item_t;

    typedef struct packed {
        logic [7:0]         byte_value;
        logic [2:0]         byte_class;
        logic [TOPIC_W-1:0] topic_length;
        logic [LEN_W-1:0]   payload_length;
        logic               qos_nonzero;
        logic [1:0]         status;
        logic               packet_end;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/mpp_input_reg.sv @@
// ----------------------------------------------------------------------------
// mpp_input_reg
// input register stage, holds one byte request until the parser takes it
// ----------------------------------------------------------------------------
`default_nettype none

module mpp_input_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output      logic          in_ready,
    input  wire mpp_pkg::item_t in_item,
    input  wire logic          advance,
    output      logic          item_valid,
    output      mpp_pkg::item_t item
);
    import mpp_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign in_ready   = !vld_reg || advance;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mpp_parse_core.sv @@
// ----------------------------------------------------------------------------
// mpp_parse_core
// publish packet state and per-byte classification
// ----------------------------------------------------------------------------
`default_nettype none

module mpp_parse_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire mpp_pkg::item_t   item,
    output      mpp_pkg::result_t result
);
    import mpp_pkg::*;

    phase_t             phase_reg, phase_next, phase_cur;
    logic [LEN_W-1:0]   rc_reg, rc_next;
    logic [1:0]         len_idx_reg, len_idx_next;
    logic [TOPIC_W-1:0] tlen_reg, tlen_next;
    logic [TOPIC_W-1:0] tleft_reg, tleft_next;
    logic [LEN_W-1:0]   plen_reg, plen_next;
    logic               qos_reg, qos_next;
    logic               id_idx_reg, id_idx_next;

    logic [7:0]         b;
    logic [LEN_W-1:0]   rc_dec;
    logic [LEN_W-1:0]   len_add;
    logic [LEN_W-1:0]   rc_sum;
    logic [TOPIC_W-1:0] tl_full;
    logic [TOPIC_W-1:0] tleft_dec;
    logic [TOPIC_W:0]   need;
    logic [2:0]         cls;
    logic [1:0]         st;
    logic               pend;

    assign b         = item.data_byte;
    assign phase_cur = item.start_of_packet ? PH_HEADER : phase_reg;
    assign rc_dec    = rc_reg - LEN_W'(1);
    assign tleft_dec = tleft_reg - TOPIC_W'(1);
    assign tl_full   = {tlen_reg[15:8], b};
    assign need      = {1'b0, tl_full} + (qos_reg ? 17'd2 : 17'd0);
    assign rc_sum    = rc_reg + len_add;

    // length digit placed by its byte position
    always_comb
    begin
        case (len_idx_reg)
            2'd0:    len_add = {21'd0, b[6:0]};
            2'd1:    len_add = {14'd0, b[6:0], 7'd0};
            2'd2:    len_add = {7'd0, b[6:0], 14'd0};
            2'd3:    len_add = {b[6:0], 21'd0};
            default: len_add = '0;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_cur;
        rc_next      = rc_reg;
        len_idx_next = len_idx_reg;
        tlen_next    = tlen_reg;
        tleft_next   = tleft_reg;
        plen_next    = plen_reg;
        qos_next     = qos_reg;
        id_idx_next  = id_idx_reg;
        cls          = CLS_DROP;
        st           = ST_OK;
        pend         = 1'b0;

        case (phase_cur)
            PH_HEADER:
            begin
                cls          = CLS_HEADER;
                rc_next      = '0;
                len_idx_next = '0;
                tlen_next    = '0;
                tleft_next   = '0;
                plen_next    = '0;
                id_idx_next  = 1'b0;
                if (b inside {HDR_QOS0, HDR_QOS1, HDR_QOS2})
                begin
                    qos_next   = (b != HDR_QOS0);
                    phase_next = PH_LENGTH;
                end
                else
                begin
                    qos_next   = 1'b0;
                    st         = ST_BAD_HEADER;
                    pend       = 1'b1;
                    phase_next = PH_DROP;
                end
            end
            PH_LENGTH:
            begin
                cls     = CLS_LENGTH;
                rc_next = rc_sum;
                if (b[7])
                begin
                    if (len_idx_reg == 2'd3)
                    begin
                        st         = ST_TOO_LONG;
                        pend       = 1'b1;
                        phase_next = PH_DROP;
                    end
                    else
                    begin
                        len_idx_next = len_idx_reg + 2'd1;
                    end
                end
                else if (rc_sum < LEN_W'(2))
                begin
                    st         = ST_BAD_LENGTH;
                    pend       = 1'b1;
                    phase_next = PH_DROP;
                end
                else
                begin
                    phase_next = PH_TLEN_HI;
                end
            end
            PH_TLEN_HI:
            begin
                cls        = CLS_TLEN;
                tlen_next  = {b, 8'd0};
                rc_next    = rc_dec;
                phase_next = PH_TLEN_LO;
            end
            PH_TLEN_LO:
            begin
                cls       = CLS_TLEN;
                tlen_next = tl_full;
                rc_next   = rc_dec;
                if (rc_dec < {11'd0, need})
                begin
                    st         = ST_BAD_LENGTH;
                    pend       = 1'b1;
                    phase_next = PH_DROP;
                end
                else
                begin
                    plen_next  = rc_dec - {11'd0, need};
                    tleft_next = tl_full;
                    if (tl_full != '0)
                    begin
                        phase_next = PH_TOPIC;
                    end
                    else if (qos_reg)
                    begin
                        id_idx_next = 1'b0;
                        phase_next  = PH_ID;
                    end
                    else if (rc_dec != '0)
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        pend       = 1'b1;
                    end
                end
            end
            PH_TOPIC:
            begin
                cls        = CLS_TOPIC;
                rc_next    = rc_dec;
                tleft_next = tleft_dec;
                if (tleft_dec == '0)
                begin
                    if (qos_reg)
                    begin
                        id_idx_next = 1'b0;
                        phase_next  = PH_ID;
                    end
                    else if (rc_dec != '0)
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        pend       = 1'b1;
                    end
                end
            end
            PH_ID:
            begin
                cls     = CLS_ID;
                rc_next = rc_dec;
                if (!id_idx_reg)
                begin
                    id_idx_next = 1'b1;
                end
                else
                begin
                    id_idx_next = 1'b0;
                    if (rc_dec != '0)
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        pend       = 1'b1;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                cls     = CLS_PAYLOAD;
                rc_next = rc_dec;
                if (rc_dec == '0)
                begin
                    phase_next = PH_HEADER;
                    pend       = 1'b1;
                end
            end
            default:
            begin
                cls        = CLS_DROP;
                phase_next = PH_DROP;
            end
        endcase
    end

    always_comb
    begin
        result.byte_value     = b;
        result.byte_class     = cls;
        result.topic_length   = tlen_next;
        result.payload_length = plen_next;
        result.qos_nonzero    = qos_next;
        result.status         = st;
        result.packet_end     = pend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            rc_reg      <= '0;
            len_idx_reg <= '0;
            tlen_reg    <= '0;
            tleft_reg   <= '0;
            plen_reg    <= '0;
            qos_reg     <= 1'b0;
            id_idx_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            rc_reg      <= rc_next;
            len_idx_reg <= len_idx_next;
            tlen_reg    <= tlen_next;
            tleft_reg   <= tleft_next;
            plen_reg    <= plen_next;
            qos_reg     <= qos_next;
            id_idx_reg  <= id_idx_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mpp_result_reg.sv @@
// ----------------------------------------------------------------------------
// mpp_result_reg
// result register with valid, held until the downstream side takes it
// ----------------------------------------------------------------------------
`default_nettype none

module mpp_result_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output      logic             advance,
    input  wire mpp_pkg::result_t result,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      mpp_pkg::result_t out_result
);
    import mpp_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign advance    = item_valid && (!vld_reg || out_ready);
    assign out_valid  = vld_reg;
    assign out_result = res_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (advance)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mqtt_publish_packet_parser_top.sv @@
// ----------------------------------------------------------------------------
// mqtt_publish_packet_parser_top
// byte-wise parser for mqtt publish packets
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | data_byte, start_of_packet
//   out     | out_valid / out_ready| byte_value, byte_class, topic_length,
//           |                      | payload_length, qos_nonzero, status,
//           |                      | packet_end
//
// one byte request per cycle sustained while out_ready stays high, one result per byte
// out_valid rises once an accepted byte has passed the input reg, then the result reg
// parse state advances when the input register hands its byte to the result reg
// with out stalled, one more byte is held in the input register
// rst_n clears the phase to expect-header and all lengths to zero
// ----------------------------------------------------------------------------
`default_nettype none

module mqtt_publish_packet_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_of_packet,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [7:0]  byte_value,
    output      logic [2:0]  byte_class,
    output      logic [15:0] topic_length,
    output      logic [27:0] payload_length,
    output      logic        qos_nonzero,
    output      logic [1:0]  status,
    output      logic        packet_end
);
    import mpp_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t out_result;

    assign in_item.data_byte       = data_byte;
    assign in_item.start_of_packet = start_of_packet;

    mpp_input_reg u_input_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mpp_parse_core u_parse_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .item   (item),
        .result (result)
    );

    mpp_result_reg u_result_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .advance    (advance),
        .result     (result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign byte_value     = out_result.byte_value;
    assign byte_class     = out_result.byte_class;
    assign topic_length   = out_result.topic_length;
    assign payload_length = out_result.payload_length;
    assign qos_nonzero    = out_result.qos_nonzero;
    assign status         = out_result.status;
    assign packet_end     = out_result.packet_end;

endmodule

`default_nettype wire

@@ rtl/core/mpp_checker.sv @@
// ----------------------------------------------------------------------------
// mpp_checker
// port-level checks for the mqtt publish parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "mqtt_publish_packet_parser_top_defines.svh"

module mpp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  data_byte,
    input wire logic        start_of_packet,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  byte_value,
    input wire logic [2:0]  byte_class,
    input wire logic [15:0] topic_length,
    input wire logic [27:0] payload_length,
    input wire logic        qos_nonzero,
    input wire logic [1:0]  status,
    input wire logic        packet_end
);
    import mpp_pkg::*;

    `MPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(byte_value) && $stable(byte_class) && $stable(status) && $stable(packet_end))
    `MPP_ASSERT_NOW(a_err_ends, out_valid && (status != ST_OK), packet_end)
    `MPP_ASSERT_NOW(a_drop_quiet, out_valid && (byte_class == CLS_DROP), (status == ST_OK) && !packet_end)
    `MPP_ASSERT_NOW(a_hdr_open, out_valid && (byte_class == CLS_HEADER) && (status == ST_OK), !packet_end && (topic_length == '0) && (payload_length == '0))

endmodule

bind mqtt_publish_packet_parser_top mpp_checker u_mpp_checker (.*);

`default_nettype wire
